// File: src/sgbf_pkg.sv
// Shared types and constants of the sample-granular byte FIFO.
package sgbf_pkg;

    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 64;
    localparam int CNT_W       = 13;
    localparam int SB_W        = 4;
    localparam int CMD_W       = 2;
    localparam int ST_W        = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 40;
    localparam int REM_W       = 3;
    localparam int STEP_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_DRAIN = 2'd2
    } cmd_e_t;

    typedef enum logic [ST_W-1:0] {
        ST_WRITE_OK      = 3'd0,
        ST_WRITE_REFUSED = 3'd1,
        ST_READ_BYTE     = 3'd2,
        ST_READ_NONE     = 3'd3,
        ST_DRAIN_DONE    = 3'd4
    } status_e_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WRITE,
        BK_READ
    } bk_state_t;

    // Decoded command handed from the front to the back.
    typedef struct packed {
        cmd_e_t              kind;
        logic [DATA_W-1:0]   data;
        logic [CNT_W-1:0]    len;
    } op_t;

    // Effective configuration seen by the back.
    typedef struct packed {
        logic [SB_W-1:0]     sample_bytes;
        logic [CNT_W-1:0]    capacity;
        logic                busy;
    } cfg_t;

    typedef struct packed {
        status_e_t           status;
        logic [BYTE_W-1:0]   read_byte;
        logic [CNT_W-1:0]    count;
        logic                last;
        logic [CNT_W-1:0]    fill_level;
    } res_t;

endpackage

// File: src/sample_granular_byte_fifo.sv
// Sample-granular byte FIFO top level: front, command queue, back and configuration.
//
// Byte ring buffer for audio samples. A write word stores one whole sample
// (sample_bytes bytes from the low end of sample_data) only if every byte fits
// in the usable capacity, else it is refused; a read word returns up to
// min(length, MAX_READ, fill) bytes, one result word per byte with tlast on the
// final one; a drain word discards up to length bytes. Usable capacity is
// capacity_bytes saturated to DEPTH and rounded down to whole samples; writing
// either register empties the buffer. Timing: the front takes a word per cycle
// into a two-entry queue while the back works, unless the queue is full or the
// configuration is busy. In the back a write puts one byte per cycle into the
// single RAM write port, the last byte waiting for a free result slot; a read
// fetches bytes through the registered RAM read port and returns one per cycle
// while the result slot is free. Results sit in an output register; the back
// hands over one per cycle while m_tready is high and stalls only when a new
// result meets one still waiting (the middle bytes of a write still go in).
// After reset and after every configuration write the block holds s_tready low
// while the capacity is rounded to whole samples one bit per cycle. The byte
// store is not cleared; the fill accounting never reads an unwritten byte.
module sample_granular_byte_fifo #(
    parameter int DEPTH            = 4096,
    parameter int MAX_READ         = 64,
    parameter int MAX_SAMPLE_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command word
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sgbf_pkg::S_TDATA_W-1:0]      s_tdata,   // sample_data[63:0], length[76:64]
    input  logic [sgbf_pkg::CMD_W-1:0]          s_tuser,   // command[1:0]
    // result word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sgbf_pkg::M_TDATA_W-1:0]      m_tdata,   // read_byte[7:0], count[20:8],
                                                           // fill_level[33:21]
    output logic [sgbf_pkg::ST_W-1:0]           m_tuser,   // status[2:0]
    output logic                                m_tlast,   // last
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sgbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgbf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sgbf_pkg::*;

    cfg_t  cfg;
    logic  clear;
    logic  push, pop;
    logic  q_valid, q_full;
    op_t   op_in, op_out;
    res_t  res;

    sgbf_cfg #(
        .DEPTH            (DEPTH),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg),
        .clear     (clear)
    );

    // front: classify and enqueue
    sgbf_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_busy (cfg.busy),
        .q_full   (q_full),
        .push     (push),
        .op       (op_in)
    );

    sgbf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .op_in   (op_in),
        .pop     (pop),
        .q_valid (q_valid),
        .q_full  (q_full),
        .op_out  (op_out)
    );

    // back: ring buffer and results
    sgbf_back #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (clear),
        .q_valid   (q_valid),
        .q_op      (op_out),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {(M_TDATA_W - BYTE_W - 2 * CNT_W)'(0), res.fill_level, res.count,
                      res.read_byte};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

// File: src/sgbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/sgbf_cfg.sv
// Configuration registers and bit-serial rounding of capacity to whole samples.
module sgbf_cfg #(
    parameter int DEPTH            = 4096,
    parameter int MAX_SAMPLE_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sgbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgbf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sgbf_pkg::cfg_t                      cfg_out,
    output logic                                clear
);
    import sgbf_pkg::*;

    logic [SB_W-1:0]   sample_reg, sample_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  cap_eff_reg, cap_eff_next;
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [SB_W-1:0]   s_eff;
    logic [CNT_W-1:0]  c_sat;
    logic [STEP_W-1:0] bit_idx;
    logic [REM_W:0]    rem_sh;
    logic [REM_W:0]    rem_sub;
    logic              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign clear     = wr;

    // zero means one byte, oversize saturates
    always_comb
    begin
        if (sample_reg == '0)
        begin
            s_eff = SB_W'(1);
        end
        else if (32'(sample_reg) > MAX_SAMPLE_BYTES)
        begin
            s_eff = SB_W'(MAX_SAMPLE_BYTES);
        end
        else
        begin
            s_eff = sample_reg;
        end
        c_sat = (32'(cap_reg) > DEPTH) ? CNT_W'(DEPTH) : cap_reg;
    end

    // restoring remainder, one capacity bit per cycle, MSB first
    assign bit_idx = STEP_W'(CNT_W - 1) - step_reg;
    assign rem_sh  = {rem_reg, c_sat[bit_idx]};
    assign rem_sub = rem_sh - (REM_W + 1)'(s_eff);

    always_comb
    begin
        sample_next  = sample_reg;
        cap_next     = cap_reg;
        cap_eff_next = cap_eff_reg;
        busy_next    = busy_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        if (wr)
        begin
            if (cfg_index == CFG_SAMPLE_BYTES)
            begin
                sample_next = cfg_data[SB_W-1:0];
            end
            else
            begin
                cap_next = cfg_data;
            end
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = (rem_sh >= (REM_W + 1)'(s_eff)) ? rem_sub[REM_W-1:0]
                                                         : rem_sh[REM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CNT_W - 1))
            begin
                busy_next    = 1'b0;
                cap_eff_next = c_sat - CNT_W'(rem_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg  <= SB_W'(2);
            cap_reg     <= CNT_W'(4096);
            cap_eff_reg <= '0;
            busy_reg    <= 1'b1;
            step_reg    <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            sample_reg  <= sample_next;
            cap_reg     <= cap_next;
            cap_eff_reg <= cap_eff_next;
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            rem_reg     <= rem_next;
        end
    end

    assign cfg_out.sample_bytes = s_eff;
    assign cfg_out.capacity     = cap_eff_reg;
    assign cfg_out.busy         = busy_reg;

endmodule

// File: src/sgbf_front.sv
// Input acceptance: decodes the command word, drops unknown commands, clamps read length.
module sgbf_front #(
    parameter int MAX_READ = 64
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sgbf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [sgbf_pkg::CMD_W-1:0]         s_tuser,
    input  logic                               cfg_busy,
    input  logic                               q_full,
    output logic                               push,
    output sgbf_pkg::op_t                      op
);
    import sgbf_pkg::*;

    logic [CNT_W-1:0] len_in;
    logic             known;

    assign len_in   = s_tdata[DATA_W +: CNT_W];
    assign s_tready = !cfg_busy && !q_full;

    always_comb
    begin
        op.kind = cmd_e_t'(s_tuser);
        op.data = s_tdata[DATA_W-1:0];
        op.len  = len_in;
        known   = 1'b1;
        case (s_tuser)
            CMD_WRITE:
            begin
                op.len = '0;
            end
            CMD_READ:
            begin
                if (32'(len_in) > MAX_READ)
                begin
                    op.len = CNT_W'(MAX_READ);
                end
            end
            CMD_DRAIN:
            begin
                op.len = len_in;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && known;

endmodule

// File: src/sgbf_queue.sv
// Two-entry command queue between front and back.
module sgbf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgbf_pkg::op_t  op_in,
    input  logic           pop,
    output logic           q_valid,
    output logic           q_full,
    output sgbf_pkg::op_t  op_out
);
    import sgbf_pkg::*;

    op_t        entry [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign q_valid = cnt_reg != 2'd0;
    assign q_full  = cnt_reg == 2'd2;
    assign op_out  = entry[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: src/sgbf_back.sv
// Execution engine: ring pointers, fill accounting, byte store and result register.
module sgbf_back #(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sgbf_pkg::cfg_t cfg,
    input  logic           clear,
    input  logic           q_valid,
    input  sgbf_pkg::op_t  q_op,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_ready,
    output sgbf_pkg::res_t res
);
    import sgbf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int XW = ((PW > CNT_W) ? PW : CNT_W) + 1;

    bk_state_t         state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [SB_W-1:0]   wleft_reg, wleft_next;
    logic [RW-1:0]     ileft_reg, ileft_next;
    logic [RW-1:0]     ecnt_reg, ecnt_next;
    logic [RW-1:0]     n_reg, n_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              ram_we, ram_re;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    logic              out_free;
    logic [XW-1:0]     tail_inc, head_inc, dsum;
    logic [PW-1:0]     tail_adv, head_adv;
    logic [PW-1:0]     drain_head;
    logic [CNT_W-1:0]  len_n;
    logic [CNT_W-1:0]  sb_ext;
    logic [CNT_W-1:0]  fill_plus;
    logic              fits;
    logic              emit, issue;
    logic [RW-1:0]     ecnt_inc;

    sgbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || res_ready;
    assign sb_ext    = CNT_W'(cfg.sample_bytes);
    assign fill_plus = fill_reg + sb_ext;
    assign fits      = (cfg.capacity - fill_reg) >= sb_ext;
    assign len_n     = (q_op.len < fill_reg) ? q_op.len : fill_reg;

    // ring wrap at the effective capacity, not at the store depth
    assign tail_inc   = XW'(tail_reg) + XW'(1);
    assign head_inc   = XW'(head_reg) + XW'(1);
    assign tail_adv   = (tail_inc == XW'(cfg.capacity)) ? '0 : tail_inc[PW-1:0];
    assign head_adv   = (head_inc == XW'(cfg.capacity)) ? '0 : head_inc[PW-1:0];
    assign dsum       = XW'(head_reg) + XW'(len_n);
    assign drain_head = (dsum >= XW'(cfg.capacity)) ? PW'(dsum - XW'(cfg.capacity))
                                                    : dsum[PW-1:0];

    // read pipeline: one byte in the RAM output register at most
    assign emit     = (state_reg == BK_READ) && pend_reg && out_free;
    assign issue    = (state_reg == BK_READ) && (ileft_reg != '0) && (!pend_reg || emit);
    assign ecnt_inc = ecnt_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        data_next      = data_reg;
        wleft_next     = wleft_reg;
        ileft_next     = ileft_reg;
        ecnt_next      = ecnt_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_wdata      = data_reg[BYTE_W-1:0];
        ram_re         = 1'b0;
        pop            = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_op.kind)
                        CMD_WRITE:
                        begin
                            if (!fits)
                            begin
                                if (out_free)
                                begin
                                    pop            = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_next       = '{ST_WRITE_REFUSED, '0, '0, 1'b1,
                                                       fill_reg};
                                end
                            end
                            else if (cfg.sample_bytes == SB_W'(1))
                            begin
                                if (out_free)
                                begin
                                    pop            = 1'b1;
                                    ram_we         = 1'b1;
                                    ram_wdata      = q_op.data[BYTE_W-1:0];
                                    tail_next      = tail_adv;
                                    fill_next      = fill_plus;
                                    out_valid_next = 1'b1;
                                    out_next       = '{ST_WRITE_OK, '0, sb_ext, 1'b1,
                                                       fill_plus};
                                end
                            end
                            else
                            begin
                                pop        = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = q_op.data[BYTE_W-1:0];
                                tail_next  = tail_adv;
                                data_next  = q_op.data >> BYTE_W;
                                wleft_next = cfg.sample_bytes - 1'b1;
                                state_next = BK_WRITE;
                            end
                        end
                        CMD_READ:
                        begin
                            if (len_n == '0 || cfg.capacity == '0)
                            begin
                                if (out_free)
                                begin
                                    pop            = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_next       = '{ST_READ_NONE, '0, '0, 1'b1,
                                                       fill_reg};
                                end
                            end
                            else
                            begin
                                pop        = 1'b1;
                                ram_re     = 1'b1;
                                head_next  = head_adv;
                                n_next     = RW'(len_n);
                                ileft_next = RW'(len_n) - 1'b1;
                                ecnt_next  = '0;
                                pend_next  = 1'b1;
                                state_next = BK_READ;
                            end
                        end
                        CMD_DRAIN:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                head_next      = (cfg.capacity == '0) ? head_reg
                                                                      : drain_head;
                                fill_next      = fill_reg - len_n;
                                out_valid_next = 1'b1;
                                out_next       = '{ST_DRAIN_DONE, '0, len_n, 1'b1,
                                                   fill_reg - len_n};
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_WRITE:
            begin
                if (wleft_reg == SB_W'(1))
                begin
                    // last byte waits for the result slot so both land together
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        tail_next      = tail_adv;
                        fill_next      = fill_plus;
                        out_valid_next = 1'b1;
                        out_next       = '{ST_WRITE_OK, '0, sb_ext, 1'b1, fill_plus};
                        state_next     = BK_IDLE;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    tail_next  = tail_adv;
                    data_next  = data_reg >> BYTE_W;
                    wleft_next = wleft_reg - 1'b1;
                end
            end
            BK_READ:
            begin
                if (issue)
                begin
                    ram_re     = 1'b1;
                    head_next  = head_adv;
                    ileft_next = ileft_reg - 1'b1;
                end
                pend_next = issue || (pend_reg && !emit);
                if (emit)
                begin
                    fill_next      = fill_reg - 1'b1;
                    ecnt_next      = ecnt_inc;
                    out_valid_next = 1'b1;
                    out_next       = '{ST_READ_BYTE, ram_rdata, CNT_W'(ecnt_inc),
                                       ecnt_inc == n_reg, fill_reg - 1'b1};
                    if (ecnt_inc == n_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            fill_next  = '0;
            pend_next  = 1'b0;
            state_next = BK_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        wleft_reg <= wleft_next;
        ileft_reg <= ileft_next;
        ecnt_reg  <= ecnt_next;
        n_reg     <= n_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// File: src/sgbf_checker.sv
// Port-level checks on the result stream of the byte FIFO, bound to the top level.
module sgbf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sgbf_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [sgbf_pkg::ST_W-1:0]       m_tuser,
    input logic                            m_tlast
);
    import sgbf_pkg::*;

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result word valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result word changed");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_READ_BYTE |-> m_tlast)
        else $error("single-result command without last");

    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_READ_BYTE |-> m_tdata[BYTE_W-1:0] == '0)
        else $error("byte field set on a non-read result");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_WRITE_OK |-> m_tdata[BYTE_W +: CNT_W] != '0)
        else $error("stored write reports zero bytes");

endmodule

bind sample_granular_byte_fifo sgbf_checker u_sgbf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
